[src/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; bodies collapse to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rst, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[src/eorb_pkg.sv]
// constants, register index codes and the q10 sine lookup for the orbit point step
// no dependencies
package eorb_pkg;

   localparam int ANGLE_W    = 8;
   localparam int QUARTER    = 64;
   localparam int SINE_W     = 12;
   localparam int Q_SHIFT    = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int POS_W      = 12;
   localparam int SCREEN_W   = 13;
   localparam int RADIUS_W   = 12;
   localparam int COLOUR_W   = 24;
   localparam int MASK_W     = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CENTRE_X,
      CSR_CENTRE_Y,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT
   } csr_index_type;

   // first quadrant, round(sin(pi*k/128)*1024) for k = 0..64
   localparam logic [10:0] QUARTER_SINE [0:64] = '{
      11'd0,    11'd25,   11'd50,   11'd75,   11'd100,  11'd125,  11'd150,
      11'd175,  11'd200,  11'd224,  11'd249,  11'd273,  11'd297,  11'd321,
      11'd345,  11'd369,  11'd392,  11'd415,  11'd438,  11'd460,  11'd483,
      11'd505,  11'd526,  11'd548,  11'd569,  11'd590,  11'd610,  11'd630,
      11'd650,  11'd669,  11'd688,  11'd706,  11'd724,  11'd742,  11'd759,
      11'd775,  11'd792,  11'd807,  11'd822,  11'd837,  11'd851,  11'd865,
      11'd878,  11'd891,  11'd903,  11'd915,  11'd926,  11'd936,  11'd946,
      11'd955,  11'd964,  11'd972,  11'd980,  11'd987,  11'd993,  11'd999,
      11'd1004, 11'd1009, 11'd1013, 11'd1016, 11'd1019, 11'd1021, 11'd1023,
      11'd1024, 11'd1024
   };

   function automatic logic signed [SINE_W-1:0] sine_q10(input logic [ANGLE_W-1:0] a);
      logic [6:0]        idx;
      logic [10:0]       mag;
      logic signed [SINE_W-1:0] v;
      // odd quadrants mirror the quarter table
      idx = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
      mag = QUARTER_SINE[idx];
      v   = $signed({1'b0, mag});
      return a[7] ? -v : v;
   endfunction

endpackage

[src/elliptical_orbit_point_step.sv]
// orbit point step: angle advance, q10 sine/cosine lookup, point and dot clipping
// depends on eorb_pkg and assert_macros.svh
// an accepted request passes the request register, then the result register, to rsp_tvalid
// throughput: one request per cycle unless rsp_tready stalls; the stage path is one 13x12 multiply, add and compares
// reset (synchronous, active high) empties both stages and loads the register defaults
// centre 0,0 and screen 1024x768
`include "assert_macros.svh"

module elliptical_orbit_point_step #(
   parameter int COORD_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: angle_in[7:0], angle_step[15:8], radius_x[27:16], radius_y[39:28],
   // dot_colour[63:40]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [63:0]                         req_tdata,
   // large_dot
   input  logic                                req_tuser,
   // response: angle_out, point_x, point_y, pixel_mask, colour_out, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((41+2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_we,
   input  logic [eorb_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [eorb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int OUT_BITS = 41 + 2*COORD_BITS;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
   localparam int EXT_W    = (COORD_BITS > 15) ? COORD_BITS : 15;
   localparam int CMP_W    = (COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15;
   localparam int PROD_W   = 25;
   localparam int OFF_W    = 13;

   // configuration registers
   logic [eorb_pkg::POS_W-1:0]    centre_x_ff, centre_y_ff;
   logic [eorb_pkg::SCREEN_W-1:0] screen_w_ff, screen_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         screen_w_ff <= 13'd1024;
         screen_h_ff <= 13'd768;
      end else if (csr_we) begin
         unique case (eorb_pkg::csr_index_type'(csr_addr))
            eorb_pkg::CSR_CENTRE_X:      centre_x_ff <= csr_wdata[eorb_pkg::POS_W-1:0];
            eorb_pkg::CSR_CENTRE_Y:      centre_y_ff <= csr_wdata[eorb_pkg::POS_W-1:0];
            eorb_pkg::CSR_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
            eorb_pkg::CSR_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request stage
   logic                           s1_valid_ff;
   logic [eorb_pkg::ANGLE_W-1:0]   s1_angle_ff, s1_step_ff;
   logic [eorb_pkg::RADIUS_W-1:0]  s1_rx_ff, s1_ry_ff;
   logic                           s1_big_ff;
   logic [eorb_pkg::COLOUR_W-1:0]  s1_colour_ff;

   // result stage
   logic                           s2_valid_ff;
   logic [eorb_pkg::ANGLE_W-1:0]   s2_angle_ff, s2_angle_in;
   logic [COORD_BITS-1:0]          s2_px_ff, s2_py_ff;
   logic signed [COORD_BITS-1:0]   s2_px_in, s2_py_in;
   logic [eorb_pkg::MASK_W-1:0]    s2_mask_ff, s2_mask_in;
   logic [eorb_pkg::COLOUR_W-1:0]  s2_colour_ff;

   logic s2_advance;

   assign s2_advance = !s2_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_angle_ff  <= req_tdata[7:0];
         s1_step_ff   <= req_tdata[15:8];
         s1_rx_ff     <= req_tdata[27:16];
         s1_ry_ff     <= req_tdata[39:28];
         s1_colour_ff <= req_tdata[63:40];
         s1_big_ff    <= req_tuser;
      end
   end

   // datapath between the two stages
   logic signed [eorb_pkg::SINE_W-1:0] cos_v, sin_v;
   logic signed [PROD_W-1:0]           prod_x, prod_y, adj_x, adj_y;
   logic signed [OFF_W-1:0]            off_x, off_y;
   logic signed [EXT_W-1:0]            sum_x, sum_y;
   logic signed [CMP_W-1:0]            ext_x, ext_y;
   logic signed [CMP_W-1:0]            lim_x, lim_y;
   logic signed [CMP_W-1:0]            cand_x [3];
   logic signed [CMP_W-1:0]            cand_y [3];
   logic [2:0]                         col_ok, row_ok;

   assign s2_angle_in = s1_angle_ff + s1_step_ff;
   assign cos_v = eorb_pkg::sine_q10(s2_angle_in + 8'(eorb_pkg::QUARTER));
   assign sin_v = eorb_pkg::sine_q10(s2_angle_in);

   assign prod_x = $signed({1'b0, s1_rx_ff}) * cos_v;
   assign prod_y = $signed({1'b0, s1_ry_ff}) * sin_v;

   // bias negative products so the shift truncates toward zero
   assign adj_x = prod_x + (prod_x[PROD_W-1] ? 25'sd1023 : 25'sd0);
   assign adj_y = prod_y + (prod_y[PROD_W-1] ? 25'sd1023 : 25'sd0);
   assign off_x = adj_x[eorb_pkg::Q_SHIFT+OFF_W-1:eorb_pkg::Q_SHIFT];
   assign off_y = adj_y[eorb_pkg::Q_SHIFT+OFF_W-1:eorb_pkg::Q_SHIFT];

   assign sum_x = EXT_W'($signed({1'b0, centre_x_ff})) + EXT_W'(off_x);
   assign sum_y = EXT_W'($signed({1'b0, centre_y_ff})) + EXT_W'(off_y);

   // wrap to the coordinate width
   assign s2_px_in = sum_x[COORD_BITS-1:0];
   assign s2_py_in = sum_y[COORD_BITS-1:0];

   assign ext_x = CMP_W'(s2_px_in);
   assign ext_y = CMP_W'(s2_py_in);
   assign lim_x = $signed(CMP_W'(screen_w_ff));
   assign lim_y = $signed(CMP_W'(screen_h_ff));

   always_comb begin
      cand_x[0] = ext_x - $signed(CMP_W'(1));
      cand_x[1] = ext_x;
      cand_x[2] = ext_x + $signed(CMP_W'(1));
      cand_y[0] = ext_y - $signed(CMP_W'(1));
      cand_y[1] = ext_y;
      cand_y[2] = ext_y + $signed(CMP_W'(1));
      for (int i = 0; i < 3; i++) begin
         col_ok[i] = !cand_x[i][CMP_W-1] && (cand_x[i] < lim_x);
         row_ok[i] = !cand_y[i][CMP_W-1] && (cand_y[i] < lim_y);
      end
      for (int dy = 0; dy < 3; dy++) begin
         for (int dx = 0; dx < 3; dx++) begin
            if (s1_big_ff || (dy == 1 && dx == 1)) begin
               s2_mask_in[3*dy+dx] = row_ok[dy] && col_ok[dx];
            end else begin
               s2_mask_in[3*dy+dx] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_advance && s1_valid_ff) begin
         s2_angle_ff  <= s2_angle_in;
         s2_px_ff     <= s2_px_in;
         s2_py_ff     <= s2_py_in;
         s2_mask_ff   <= s2_mask_in;
         s2_colour_ff <= s1_colour_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = OUT_W'({s2_colour_ff, s2_mask_ff, s2_py_ff, s2_px_ff, s2_angle_ff});

   // an accepted request always lands in the request stage
   `ASSERT_AT(a_req_lands, clock, reset, (req_tvalid && req_tready) |=> s1_valid_ff)
   // a blocked request stage keeps its item
   `ASSERT_AT(a_s1_holds, clock, reset, (s1_valid_ff && !s2_advance) |=> (s1_valid_ff && $stable(s1_angle_ff) && $stable(s1_colour_ff)))
   // an empty request stage never stalls the request side
   `ASSERT_AT(a_ready_when_empty, clock, reset, !s1_valid_ff |-> req_tready)
   // with nothing behind it, a taken result leaves the output empty
   `ASSERT_AT(a_drain, clock, reset, (rsp_tvalid && rsp_tready && !s1_valid_ff) |=> !rsp_tvalid)

endmodule
